// ----- design/trw_pkg.sv -----
package trw_pkg;

    localparam int STAMP_W = 48;
    localparam int TAG_W   = 16;
    localparam int THR_W   = 6;
    localparam int DATA_W  = 2 * STAMP_W + TAG_W;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(20);

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    typedef struct packed {
        logic        [TAG_W-1:0]   tag;
        logic signed [STAMP_W-1:0] present;
        logic signed [STAMP_W-1:0] decode;
    } entry_t;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_CHECK    = 8'b0000_0010,
        ST_SCAN     = 8'b0000_0100,
        ST_SHIFT_RD = 8'b0000_1000,
        ST_SHIFT_WR = 8'b0001_0000,
        ST_FIX      = 8'b0010_0000,
        ST_DRIFT    = 8'b0100_0000,
        ST_OUT      = 8'b1000_0000
    } state_t;

endpackage

// ----- design/trw_store.sv -----
module trw_store #(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  trw_pkg::entry_t      wr_data,
    input  logic [IDX_W-1:0]     rd_addr,
    output trw_pkg::entry_t      rd_data
);
    import trw_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/timestamp_reorder_window.sv -----
// Channel  Dir  tdata (low bit up)                        tuser         tlast
// s_       in   decode_stamp, present_stamp, packet_tag   kind          -
// m_       out  out_decode_stamp, out_present_stamp,      was_shifted   last_of_run
//               out_tag
// cfg_     in   cfg_wdata = emit_threshold, written when cfg_wen is high
//
// Each emit scans the held entries (one per cycle through the store's read port),
// then closes the gap by reading and rewriting each later entry (ST_SHIFT_RD, then
// ST_SHIFT_WR), then steps through ST_FIX, ST_DRIFT and ST_OUT for the fix and the
// output; each emit follows a check. An item is accepted in idle and ends with a final check.
// s_tready is high only in the idle state; the block accepts a new item while the
// last result of the previous one still waits in the output register.
// A stalled m_ side holds the sequencer before each result. Reset empties the window
// and sets the threshold to 20; store contents are not cleared.
module timestamp_reorder_window #(
    parameter int WINDOW_CAPACITY = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wen,
    input  logic [trw_pkg::THR_W-1:0]    cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [trw_pkg::DATA_W-1:0]   s_tdata,   // decode_stamp, present_stamp, packet_tag
    input  logic                         s_tuser,   // kind
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [trw_pkg::DATA_W-1:0]   m_tdata,   // out_decode_stamp, out_present_stamp, out_tag
    output logic                         m_tuser,   // was_shifted
    output logic                         m_tlast
);
    import trw_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_CAPACITY);
    localparam int CNT_W = $clog2(WINDOW_CAPACITY + 1);

    state_t state_reg, state_next;
    logic [THR_W-1:0]   thr_reg, thr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               flush_reg, flush_next;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    entry_t             best_reg, best_next;
    logic [IDX_W-1:0]   sh_idx_reg, sh_idx_next;
    logic               cond_reg, cond_next;
    logic [STAMP_W-1:0] target_reg, target_next;
    logic [STAMP_W-1:0] drift_reg, drift_next;
    logic [STAMP_W-1:0] prev_reg, prev_next;
    logic               prev_valid_reg, prev_valid_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;
    logic               m_tlast_reg, m_tlast_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic [IDX_W-1:0]   rd_addr;
    entry_t             rd_data;

    logic [CNT_W-1:0]   thr_eff;
    entry_t             in_entry;
    entry_t             res;
    logic               more;
    logic               last;

    trw_store #(
        .DEPTH (WINDOW_CAPACITY),
        .IDX_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_entry = entry_t'(s_tdata);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        if (thr_reg == '0) begin
            thr_eff = CNT_W'(1);
        end else if (32'(thr_reg) > 32'(WINDOW_CAPACITY)) begin
            thr_eff = CNT_W'(WINDOW_CAPACITY);
        end else begin
            thr_eff = CNT_W'(thr_reg);
        end
    end

    assign more = (count_reg != '0) && (flush_reg || (count_reg >= thr_eff));
    assign last = flush_reg ? (count_reg == '0) : (count_reg < thr_eff);

    always_comb begin
        res.tag     = best_reg.tag;
        res.decode  = cond_reg ? target_reg : best_reg.decode;
        res.present = cond_reg ? best_reg.present + drift_reg : best_reg.present;
    end

    always_comb begin
        state_next      = state_reg;
        thr_next        = cfg_wen ? cfg_wdata : thr_reg;
        count_next      = count_reg;
        flush_next      = flush_reg;
        scan_idx_next   = scan_idx_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        sh_idx_next     = sh_idx_reg;
        cond_next       = cond_reg;
        target_next     = target_reg;
        drift_next      = drift_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tlast_next    = m_tlast_reg;
        wr_en           = 1'b0;
        wr_addr         = IDX_W'(count_reg);
        wr_data         = in_entry;
        rd_addr         = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    flush_next = (s_tuser == KIND_FLUSH);
                    state_next = ST_CHECK;
                    if (s_tuser == KIND_INSERT && count_reg < CNT_W'(WINDOW_CAPACITY)) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                scan_idx_next = '0;
                if (more) begin
                    state_next = ST_SCAN;
                end else begin
                    if (flush_reg) begin
                        prev_valid_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                rd_addr = scan_idx_reg + 1'b1;
                if (scan_idx_reg == '0 || rd_data.decode < best_reg.decode) begin
                    best_next     = rd_data;
                    best_idx_next = scan_idx_reg;
                end
                scan_idx_next = scan_idx_reg + 1'b1;
                if (CNT_W'(scan_idx_reg) + 1'b1 == count_reg) begin
                    sh_idx_next = best_idx_next;
                    state_next  = ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD: begin
                rd_addr = sh_idx_reg + 1'b1;
                if (CNT_W'(sh_idx_reg) + 1'b1 < count_reg) begin
                    state_next = ST_SHIFT_WR;
                end else begin
                    state_next = ST_FIX;
                end
            end
            ST_SHIFT_WR: begin
                wr_en       = 1'b1;
                wr_addr     = sh_idx_reg;
                wr_data     = rd_data;
                sh_idx_next = sh_idx_reg + 1'b1;
                state_next  = ST_SHIFT_RD;
            end
            ST_FIX: begin
                count_next  = count_reg - 1'b1;
                cond_next   = prev_valid_reg && (best_reg.decode <= $signed(prev_reg));
                target_next = prev_reg + 1'b1;
                state_next  = ST_DRIFT;
            end
            ST_DRIFT: begin
                drift_next = target_reg - best_reg.decode;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next   = 1'b1;
                    m_tdata_next    = DATA_W'(res);
                    m_tuser_next    = cond_reg;
                    m_tlast_next    = last;
                    prev_next       = res.decode;
                    prev_valid_next = 1'b1;
                    state_next      = ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            thr_reg        <= THR_RESET;
            count_reg      <= '0;
            flush_reg      <= 1'b0;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            thr_reg        <= thr_next;
            count_reg      <= count_next;
            flush_reg      <= flush_next;
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        sh_idx_reg   <= sh_idx_next;
        cond_reg     <= cond_next;
        target_reg   <= target_next;
        drift_reg    <= drift_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        m_tlast_reg  <= m_tlast_next;
    end

endmodule
